// ===== rtl/adsr_pkg.sv =====
// Shared types and constants of the ADSR envelope voice bank.
package adsr_pkg;

    // Fixed field widths
    localparam int CFG_TIME_W = 20;
    localparam int LEVEL_W    = 16;
    localparam int OP_W       = 2;
    localparam int VOICE_W    = 7;
    localparam int CFG_IDX_W  = 2;

    // Full scale of a Q1.15 level
    localparam logic [LEVEL_W-1:0] FULL_SCALE = 16'h8000;

    // Serial multiplier and divider geometry
    localparam int MUL_STEPS = LEVEL_W / 2;          // radix-4 digits of the level operand
    localparam int PROD_W    = CFG_TIME_W + LEVEL_W; // product width
    localparam int CNT_W     = 4;                    // counts up to LEVEL_W - 1

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_KEY_ON  = 2'd1;
    localparam logic [OP_W-1:0] OP_KEY_OFF = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

    // Reset values of the configuration registers
    localparam logic [CFG_TIME_W-1:0] ATTACK_RST  = 20'd2205;
    localparam logic [CFG_TIME_W-1:0] DECAY_RST   = 20'd2205;
    localparam logic [LEVEL_W-1:0]    SUSTAIN_RST = 16'h8000;
    localparam logic [CFG_TIME_W-1:0] RELEASE_RST = 20'd22050;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_WRITE
    } adsr_state_t;

endpackage

// ===== rtl/adsr_envelope_voice_bank_unit.sv =====
// Top level of the ADSR envelope voice bank: voice store, sequencer and serial mul/div.
//
//  channel  | ports                                   | direction | word
//  ---------+-----------------------------------------+-----------+---------------------------
//  s_       | s_valid s_ready s_op s_voice            | in        | tick / key-on / key-off
//  m_       | m_valid m_ready m_level m_live          | out       | level and live after word
//  cfg_     | cfg_wr_en cfg_index cfg_wdata           | in        | register write, no wait
//
//  A word that needs a division (attack, decay or release slope of a live voice) passes
//  through one memory read, one phase decision, 8 radix-4 multiply steps and
//  16 restoring-divide steps, then the write-back. Any other word skips the multiply and
//  divide steps. The shared serial multiplier/divider sets the pace; one word at a time.
//  Reset (aresetn low at a clock edge) clears the per-voice valid bits, so every voice
//  reads as dead with level 0; there is no clearing pass. A stalled result sits in the
//  output register while the next word is accepted; write-back waits only for that slot.
module adsr_envelope_voice_bank_unit #(
    parameter int VOICES    = 128,
    parameter int TIME_BITS = 20
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [adsr_pkg::OP_W-1:0]             s_op,
    input  logic [adsr_pkg::VOICE_W-1:0]          s_voice,
    // result channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]          m_level,
    output logic                                  m_live,
    // configuration port
    input  logic                                  cfg_wr_en,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [adsr_pkg::CFG_TIME_W-1:0]       cfg_wdata
);

    localparam int TW     = adsr_pkg::CFG_TIME_W;
    localparam int LW     = adsr_pkg::LEVEL_W;
    localparam int PW     = adsr_pkg::PROD_W;
    localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
    // compare width: holds an age, a time and the sum of two times
    localparam int CMP_W  = ((TIME_BITS > TW) ? TIME_BITS : TW) + 1;
    // memory word: {age, release age, level, held, live}
    localparam int MEM_W  = 2 * TIME_BITS + LW + 2;
    localparam int LIVE_B = 0;
    localparam int HELD_B = 1;
    localparam int LVL_LO = 2;
    localparam int RAG_LO = LVL_LO + LW;
    localparam int AGE_LO = RAG_LO + TIME_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TW-1:0] attack_reg;
    logic [TW-1:0] decay_reg;
    logic [LW-1:0] sustain_reg;
    logic [TW-1:0] release_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_reg  <= adsr_pkg::ATTACK_RST;
            decay_reg   <= adsr_pkg::DECAY_RST;
            sustain_reg <= adsr_pkg::SUSTAIN_RST;
            release_reg <= adsr_pkg::RELEASE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                adsr_pkg::CFG_ATTACK:  attack_reg  <= cfg_wdata;
                adsr_pkg::CFG_DECAY:   decay_reg   <= cfg_wdata;
                adsr_pkg::CFG_SUSTAIN: sustain_reg <= cfg_wdata[LW-1:0];
                adsr_pkg::CFG_RELEASE: release_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sustain above full scale acts as full scale
    logic [LW-1:0] sus_sat;
    assign sus_sat = (sustain_reg > adsr_pkg::FULL_SCALE) ? adsr_pkg::FULL_SCALE : sustain_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    adsr_pkg::adsr_state_t state_reg, state_next;

    logic                  out_free;
    logic                  accept;
    logic                  mem_wr;
    logic                  out_load;
    logic                  start_div;
    logic                  inr_reg;
    logic [adsr_pkg::CNT_W-1:0] cnt_reg;

    logic                  m_valid_reg;
    logic [LW-1:0]         m_level_reg;
    logic                  m_live_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= adsr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mem_wr     = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            adsr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = adsr_pkg::ST_EVAL;
                end
            end
            adsr_pkg::ST_EVAL: begin
                state_next = start_div ? adsr_pkg::ST_MUL : adsr_pkg::ST_WRITE;
            end
            adsr_pkg::ST_MUL: begin
                if (cnt_reg == adsr_pkg::CNT_W'(adsr_pkg::MUL_STEPS - 1)) begin
                    state_next = adsr_pkg::ST_DIV;
                end
            end
            adsr_pkg::ST_DIV: begin
                if (cnt_reg == adsr_pkg::CNT_W'(LW - 1)) begin
                    state_next = adsr_pkg::ST_WRITE;
                end
            end
            adsr_pkg::ST_WRITE: begin
                // hold until the output slot is free, then commit and answer together
                if (out_free) begin
                    out_load   = 1'b1;
                    mem_wr     = inr_reg;
                    state_next = adsr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = adsr_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Voice store: one word per voice, valid bits stand in for the reset
    // ------------------------------------------------------------------
    logic [MEM_W-1:0]      voice_mem [VOICES];
    logic [MEM_W-1:0]      rd_data_reg;
    logic [VOICES-1:0]     vld_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [adsr_pkg::OP_W-1:0] op_reg;
    logic [IDX_W-1:0]      s_idx;
    logic [MEM_W-1:0]      wr_data;

    assign s_idx = IDX_W'(s_voice);

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            voice_mem[idx_reg] <= wr_data;
        end
        if (accept) begin
            rd_data_reg <= voice_mem[s_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (mem_wr) begin
            vld_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg     <= s_op;
            idx_reg    <= s_idx;
            inr_reg    <= (32'(s_voice) < 32'(VOICES));
            rd_vld_reg <= vld_reg[s_idx];
        end
    end

    // ------------------------------------------------------------------
    // Phase decision for the word just read
    // ------------------------------------------------------------------
    logic [MEM_W-1:0]     ent;
    logic [TIME_BITS-1:0] e_age, e_rage, age_inc, rage_inc;
    logic [LW-1:0]        e_level;
    logic                 e_held, e_live;
    logic [CMP_W-1:0]     t_ext, u_ext, a_ext, ad_ext, r_ext;

    logic [TIME_BITS-1:0] n_age, n_rage;
    logic [LW-1:0]        n_level;
    logic                 n_held, n_live;
    logic [TW-1:0]        x_op, d_op;
    logic [LW-1:0]        y_op;
    logic                 sub_op;

    // an entry never written reads as a dead voice at level 0
    assign ent      = rd_vld_reg ? rd_data_reg : '0;
    assign e_age    = ent[AGE_LO +: TIME_BITS];
    assign e_rage   = ent[RAG_LO +: TIME_BITS];
    assign e_level  = ent[LVL_LO +: LW];
    assign e_held   = ent[HELD_B];
    assign e_live   = ent[LIVE_B];

    assign age_inc  = (e_age  == '1) ? e_age  : e_age  + 1'b1;
    assign rage_inc = (e_rage == '1) ? e_rage : e_rage + 1'b1;

    assign t_ext  = CMP_W'(e_age);
    assign u_ext  = CMP_W'(e_rage);
    assign a_ext  = CMP_W'(attack_reg);
    assign r_ext  = CMP_W'(release_reg);
    assign ad_ext = CMP_W'(attack_reg) + CMP_W'(decay_reg);

    always_comb begin
        n_age     = e_age;
        n_rage    = e_rage;
        n_level   = e_level;
        n_held    = e_held;
        n_live    = e_live;
        start_div = 1'b0;
        x_op      = '0;
        y_op      = '0;
        d_op      = '0;
        sub_op    = 1'b0;
        if (state_reg == adsr_pkg::ST_EVAL && inr_reg) begin
            case (op_reg)
                adsr_pkg::OP_KEY_ON: begin
                    n_age   = '0;
                    n_rage  = '0;
                    n_level = '0;
                    n_held  = 1'b1;
                    n_live  = 1'b1;
                end
                adsr_pkg::OP_KEY_OFF: begin
                    n_held = 1'b0;
                end
                adsr_pkg::OP_TICK: begin
                    if (e_live) begin
                        n_age = age_inc;
                        if (!e_held) begin
                            n_rage = rage_inc;
                        end
                        if (t_ext <= a_ext) begin
                            // attack ramp: age * full / attack
                            if (attack_reg == '0) begin
                                n_level = adsr_pkg::FULL_SCALE;
                            end else begin
                                start_div = 1'b1;
                                x_op      = TW'(t_ext);
                                y_op      = adsr_pkg::FULL_SCALE;
                                d_op      = attack_reg;
                            end
                        end else if (t_ext <= ad_ext) begin
                            // decay: full - (age - attack) * (full - sustain) / decay
                            start_div = 1'b1;
                            sub_op    = 1'b1;
                            x_op      = TW'(t_ext - a_ext);
                            y_op      = adsr_pkg::FULL_SCALE - sus_sat;
                            d_op      = decay_reg;
                        end else if (e_held) begin
                            n_level = sus_sat;
                        end else if (release_reg == '0) begin
                            n_level = '0;
                        end else if (u_ext >= r_ext || sus_sat == '0) begin
                            // release ran out: drop to zero and retire the voice
                            n_level = '0;
                            n_live  = 1'b0;
                        end else begin
                            start_div = 1'b1;
                            x_op      = TW'(r_ext - u_ext);
                            y_op      = sus_sat;
                            d_op      = release_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Serial multiply (radix 4, level operand MSB first) and divide (radix 2)
    // ------------------------------------------------------------------
    logic [TW-1:0]   mcand_reg;
    logic [TW+1:0]   mcand3_reg;
    logic [LW-1:0]   mplier_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   addend;
    logic [PW-1:0]   acc_next;
    logic [TW-1:0]   div_reg;
    logic [TW-1:0]   rem_reg;
    logic [LW-1:0]   quo_reg;
    logic            sub_reg;
    logic [TW:0]     trial;
    logic            trial_ge;
    logic [TW-1:0]   rem_next;
    logic [LW-1:0]   quo_next;

    always_comb begin
        case (mplier_reg[LW-1 -: 2])
            2'd1:    addend = PW'(mcand_reg);
            2'd2:    addend = PW'({mcand_reg, 1'b0});
            2'd3:    addend = PW'(mcand3_reg);
            default: addend = '0;
        endcase
    end

    assign acc_next = {acc_reg[PW-3:0], 2'b00} + addend;

    assign trial    = {rem_reg, quo_reg[LW-1]};
    assign trial_ge = (trial >= {1'b0, div_reg});
    assign rem_next = trial_ge ? TW'(trial - {1'b0, div_reg}) : trial[TW-1:0];
    assign quo_next = {quo_reg[LW-2:0], trial_ge};

    // result and write-back fields
    logic [TIME_BITS-1:0] new_age_reg, new_rage_reg;
    logic                 new_held_reg;
    logic [LW-1:0]        res_level_reg;
    logic                 res_live_reg;

    assign wr_data = {new_age_reg, new_rage_reg, res_level_reg, new_held_reg, res_live_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            case (state_reg)
                adsr_pkg::ST_MUL: begin
                    cnt_reg <= (cnt_reg == adsr_pkg::CNT_W'(adsr_pkg::MUL_STEPS - 1))
                               ? '0 : cnt_reg + 1'b1;
                end
                adsr_pkg::ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                default: begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            adsr_pkg::ST_EVAL: begin
                new_age_reg   <= n_age;
                new_rage_reg  <= n_rage;
                new_held_reg  <= n_held;
                res_level_reg <= inr_reg ? n_level : '0;
                res_live_reg  <= inr_reg ? n_live  : 1'b0;
                mcand_reg     <= x_op;
                mcand3_reg    <= {2'b00, x_op} + {1'b0, x_op, 1'b0};
                mplier_reg    <= y_op;
                div_reg       <= d_op;
                sub_reg       <= sub_op;
                acc_reg       <= '0;
            end
            adsr_pkg::ST_MUL: begin
                acc_reg    <= acc_next;
                mplier_reg <= {mplier_reg[LW-3:0], 2'b00};
                if (cnt_reg == adsr_pkg::CNT_W'(adsr_pkg::MUL_STEPS - 1)) begin
                    // quotient fits 16 bits, so the upper part is already below the divisor
                    rem_reg <= acc_next[PW-1 -: TW];
                    quo_reg <= acc_next[LW-1:0];
                end
            end
            adsr_pkg::ST_DIV: begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (cnt_reg == adsr_pkg::CNT_W'(LW - 1)) begin
                    res_level_reg <= sub_reg ? adsr_pkg::FULL_SCALE - quo_next : quo_next;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_level_reg <= res_level_reg;
            m_live_reg  <= res_live_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_level = m_level_reg;
    assign m_live  = m_live_reg;

endmodule
